FILE: rtl/core/lqc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lqc_pkg
// Shared types and constants for the linear queue with compaction: beat
// field widths, operation and status codes, and the controller to datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package lqc_pkg;

    localparam int KIND_W             = 2;
    localparam int VALUE_W            = 32;
    localparam int STATUS_W           = 2;
    localparam int OCC_W              = 9;
    localparam int CAP_W              = 9;
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    localparam int DEPTH_DEFAULT      = 256;
    localparam int DATA_WIDTH_DEFAULT = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT  = 2'd0,
        KIND_REMOVE  = 2'd1,
        KIND_CLEAR   = 2'd2,
        KIND_COMPACT = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic    insert;
        logic    remove;
        logic    clear;
        logic    rebase;
        logic    copy_start;
        logic    copy_step;
        logic    load;
        logic    res_from_mem;
        status_t res_status;
    } lqc_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic compact_trivial;
        logic copy_done;
    } lqc_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/lqc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lqc_if
// Valid/ready channels of the queue: request beats, response beats and
// capacity configuration writes.
// ----------------------------------------------------------------------------
interface lqc_req_if import lqc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    kind_t                     kind;
    logic signed [VALUE_W-1:0] value_in;

    modport source (output valid, output kind, output value_in, input ready);
    modport sink (input valid, input kind, input value_in, output ready);
endinterface

interface lqc_rsp_if import lqc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    status_t                   status;
    logic signed [VALUE_W-1:0] value_out;
    logic [OCC_W-1:0]          occupancy;

    modport source (output valid, output status, output value_out, output occupancy,
                    input ready);
    modport sink (input valid, input status, input value_out, input occupancy,
                  output ready);
endinterface

interface lqc_cfg_if import lqc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] capacity_in_use;

    modport source (output valid, output capacity_in_use, input ready);
    modport sink (input valid, input capacity_in_use, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/lqc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lqc_ctrl
// Controller state machine: accepts request beats, sequences removes and
// compaction copies in the datapath, and owns the response valid flag.
// ----------------------------------------------------------------------------
module lqc_ctrl import lqc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  kind_t     req_kind,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    input  lqc_stat_t stat,
    output lqc_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_COPY = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   res_valid_reg;
    logic   res_valid_next;
    logic   slot_free;
    logic   accept;

    assign slot_free = !res_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = res_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = slot_free;
                if (req_valid && slot_free)
                begin
                    unique case (req_kind)
                        KIND_INSERT:
                        begin
                            cmd.load = 1'b1;
                            if (stat.full)
                            begin
                                cmd.res_status = STATUS_FULL;
                            end
                            else
                            begin
                                cmd.insert = 1'b1;
                            end
                        end
                        KIND_REMOVE:
                        begin
                            if (stat.empty)
                            begin
                                cmd.load       = 1'b1;
                                cmd.res_status = STATUS_EMPTY;
                            end
                            else
                            begin
                                cmd.remove = 1'b1;
                                state_next = ST_READ;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                            cmd.load  = 1'b1;
                        end
                        KIND_COMPACT:
                        begin
                            if (stat.compact_trivial)
                            begin
                                cmd.rebase = 1'b1;
                                cmd.load   = 1'b1;
                            end
                            else
                            begin
                                cmd.copy_start = 1'b1;
                                state_next     = ST_COPY;
                            end
                        end
                        default:
                        begin
                            cmd.load = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                cmd.load         = 1'b1;
                cmd.res_from_mem = 1'b1;
                state_next       = ST_IDLE;
            end
            ST_COPY:
            begin
                if (stat.copy_done)
                begin
                    cmd.rebase = 1'b1;
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.copy_step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.load)
        begin
            res_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // The response slot must be free whenever a multi-cycle operation is running.
    a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ || state_reg == ST_COPY) |-> !res_valid_reg)
        else $error("response slot occupied during a multi-cycle operation");

    a_remove_goes_read: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_kind == KIND_REMOVE && !stat.empty) |=> (state_reg == ST_READ))
        else $error("remove of a non-empty queue did not enter the read state");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> res_valid_reg)
        else $error("loaded response beat not presented");

    a_copy_keeps_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COPY && !stat.copy_done) |=> (state_reg == ST_COPY))
        else $error("compaction left before the copy finished");

endmodule
`default_nettype wire

FILE: rtl/core/lqc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lqc_datapath
// Entry memory with one write and one registered read port, head and tail
// indices, compaction copy pointers, capacity register and the response
// payload registers.
// ----------------------------------------------------------------------------
module lqc_datapath import lqc_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    input  logic [CAP_W-1:0]          cfg_data,
    input  logic signed [VALUE_W-1:0] value_in,
    input  lqc_cmd_t                  cmd,
    output lqc_stat_t                 stat,
    output status_t                   res_status,
    output logic signed [VALUE_W-1:0] res_value,
    output logic [OCC_W-1:0]          res_occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int IW = $clog2(DEPTH + 1);
    localparam int CW = (IW > CAP_W) ? IW : CAP_W;

    logic [DATA_WIDTH-1:0] mem_array [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic [CAP_W-1:0]      cap_reg;
    logic [IW-1:0]         head_reg;
    logic [IW-1:0]         head_next;
    logic [IW-1:0]         tail_reg;
    logic [IW-1:0]         tail_next;
    logic [IW-1:0]         src_reg;
    logic [IW-1:0]         src_next;
    logic [AW-1:0]         dst_reg;
    logic [AW-1:0]         dst_next;
    logic                  cp_valid_reg;
    logic                  cp_valid_next;

    status_t               res_status_reg;
    logic [VALUE_W-1:0]    res_value_reg;
    logic [OCC_W-1:0]      res_occ_reg;

    logic [IW-1:0]         live;
    logic                  src_more;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] din;
    logic [VALUE_W-1:0]    dout;

    generate
        if (DATA_WIDTH <= VALUE_W)
        begin : g_din_narrow
            assign din = value_in[DATA_WIDTH-1:0];
        end
        else
        begin : g_din_wide
            assign din = {{(DATA_WIDTH-VALUE_W){value_in[VALUE_W-1]}}, value_in};
        end
        if (DATA_WIDTH >= VALUE_W)
        begin : g_dout_wide
            assign dout = rd_data_reg[VALUE_W-1:0];
        end
        else
        begin : g_dout_narrow
            assign dout = {{(VALUE_W-DATA_WIDTH){rd_data_reg[DATA_WIDTH-1]}}, rd_data_reg};
        end
    endgenerate

    assign live     = tail_reg - head_reg;
    assign src_more = (src_reg != tail_reg);

    assign stat.full = (CW'(tail_reg) >= CW'(cap_reg)) || (CW'(tail_reg) >= CW'(DEPTH));
    assign stat.empty           = (head_reg == tail_reg);
    assign stat.compact_trivial = (live == '0) || (head_reg == '0);
    assign stat.copy_done       = !src_more && !cp_valid_reg;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (cmd.insert)
        begin
            tail_next = tail_reg + 1'b1;
        end
        if (cmd.remove)
        begin
            head_next = head_reg + 1'b1;
        end
        if (cmd.clear)
        begin
            head_next = '0;
            tail_next = '0;
        end
        if (cmd.rebase)
        begin
            head_next = '0;
            tail_next = live;
        end
    end

    always_comb
    begin
        src_next      = src_reg;
        dst_next      = dst_reg;
        cp_valid_next = 1'b0;
        if (cmd.copy_start)
        begin
            src_next = head_reg;
            dst_next = '0;
        end
        else if (cmd.copy_step)
        begin
            cp_valid_next = src_more;
            if (src_more)
            begin
                src_next = src_reg + 1'b1;
            end
            if (cp_valid_reg)
            begin
                dst_next = dst_reg + 1'b1;
            end
        end
    end

    assign wr_en   = cmd.insert || (cmd.copy_step && cp_valid_reg);
    assign wr_addr = cmd.insert ? tail_reg[AW-1:0] : dst_reg;
    assign wr_data = cmd.insert ? din : rd_data_reg;
    assign rd_en   = cmd.remove || (cmd.copy_step && src_more);
    assign rd_addr = cmd.remove ? head_reg[AW-1:0] : src_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg      <= CAP_RESET;
            head_reg     <= '0;
            tail_reg     <= '0;
            cp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            cp_valid_reg <= cp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg <= src_next;
        dst_reg <= dst_next;
        if (cmd.load)
        begin
            res_status_reg <= cmd.res_status;
            res_value_reg  <= cmd.res_from_mem ? dout : '0;
            res_occ_reg    <= OCC_W'(tail_next - head_next);
        end
    end

    assign res_status    = res_status_reg;
    assign res_value     = res_value_reg;
    assign res_occupancy = res_occ_reg;

    a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("head index passed the tail index");

    // A pending copy write always lands below the slot being read next.
    a_copy_order: assert property (@(posedge clk) disable iff (!rst_n)
        cp_valid_reg |-> (IW'(dst_reg) < src_reg))
        else $error("compaction write overtook the read pointer");

    a_no_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.insert && (cmd.copy_step || cmd.remove)))
        else $error("conflicting memory commands");

endmodule
`default_nettype wire

FILE: rtl/core/linear_queue_with_compaction.sv
`default_nettype none
// Insert, clear and any failed or no-move operation: the response is registered
// from the request beat and shown in the next cycle; one request beat per cycle
// while the response is taken. Remove: the memory read is registered, then the
// response is loaded from it, and no new beat is taken before that. Compact with
// entries to move: one entry per cycle through the single memory read and write
// port. Reset zeroes head and tail and sets the capacity to 256; the entry memory is not cleared.
// ----------------------------------------------------------------------------
// linear_queue_with_compaction
// Linear, non-wrapping array queue with insert, remove, clear and compaction
// toward slot zero, built from a controller and a datapath.
// ----------------------------------------------------------------------------
module linear_queue_with_compaction import lqc_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    lqc_req_if.sink    req,
    lqc_rsp_if.source  rsp,
    lqc_cfg_if.sink    cfg
);

    lqc_cmd_t  cmd;
    lqc_stat_t stat;

    assign cfg.ready = 1'b1;

    lqc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req_kind  (req.kind),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    lqc_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg.valid),
        .cfg_data      (cfg.capacity_in_use),
        .value_in      (req.value_in),
        .cmd           (cmd),
        .stat          (stat),
        .res_status    (rsp.status),
        .res_value     (rsp.value_out),
        .res_occupancy (rsp.occupancy)
    );

endmodule
`default_nettype wire
